// ===== rtl/mts_pkg.sv =====
// Shared types and codes for the minimum-tracking stack.
// No dependencies; imported by the core.
package mts_pkg;

    // Operation codes carried on the opcode port
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Completion status of one transaction
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

endpackage

// ===== rtl/mts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for both stack stores.
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/min_tracking_stack_core.sv =====
// Minimum-tracking stack core: value stack plus running-minima stack.
// Depends on mts_pkg and mts_ram.
//
//  channel   | handshake           | payload
//  ----------+---------------------+---------------------------------------------
//  command   | start, busy         | opcode, push_value
//  result    | done (1-cycle pulse)| top_value, min_value, depth_used, is_empty,
//            |                     | status
//
// One transaction is accepted per cycle (busy is never raised); its result
// appears on the cycle after acceptance, marked by done for that cycle only.
// The rate is set by the top-of-stack registers and a read-ahead of the entry
// below the top from each RAM, addressed from the next count each cycle.
// Reset (rst_n low, asynchronous) empties both stacks; the RAMs keep their
// contents, as only entries below the count are ever read. No clearing pass.
// The receiver cannot stall: each result is taken in its own cycle.
module min_tracking_stack_core
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   opcode,
    input  logic signed [VALUE_WIDTH-1:0]          push_value,
    output logic                                   done,
    output logic signed [VALUE_WIDTH-1:0]          top_value,
    output logic signed [VALUE_WIDTH-1:0]          min_value,
    output logic [$clog2(STACK_DEPTH+1)-1:0]       depth_used,
    output logic                                   is_empty,
    output logic [1:0]                             status
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = $clog2(STACK_DEPTH);

    localparam logic [CNT_W-1:0]       CNT_MAX = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0]       CNT_TWO = CNT_W'(2);
    localparam logic [CNT_W-1:0]       CNT_ONE = CNT_W'(1);
    localparam logic [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    // Stack state: counts plus cached top of each store
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              mcount_reg, mcount_next;
    logic signed [VALUE_WIDTH-1:0] top_reg, top_next;
    logic signed [VALUE_WIDTH-1:0] mtop_reg, mtop_next;

    // Result register
    logic                          done_reg;
    logic signed [VALUE_WIDTH-1:0] top_value_reg, top_value_next;
    logic signed [VALUE_WIDTH-1:0] min_value_reg, min_value_next;
    logic [CNT_W-1:0]              depth_used_reg;
    logic                          is_empty_reg;
    status_t                       status_reg, status_next;

    // RAM ports
    logic                   vram_we, mram_we;
    logic [AW-1:0]          vram_waddr, mram_waddr;
    logic [AW-1:0]          vram_raddr, mram_raddr;
    logic [VALUE_WIDTH-1:0] sec_data, msec_data;
    logic [CNT_W-1:0]       vram_rcnt, mram_rcnt;

    logic stack_full;
    logic stack_empty;
    logic new_min;

    assign stack_full  = (count_reg == CNT_MAX);
    assign stack_empty = (count_reg == '0);
    // Inclusive compare so that duplicate minima are kept
    assign new_min     = (mcount_reg == '0) || (push_value <= mtop_reg);

    assign vram_waddr = count_reg[AW-1:0];
    assign mram_waddr = mcount_reg[AW-1:0];

    // Read ahead the entry below the next top; only used when that count >= 2
    assign vram_rcnt  = count_next - CNT_TWO;
    assign mram_rcnt  = mcount_next - CNT_TWO;
    assign vram_raddr = vram_rcnt[AW-1:0];
    assign mram_raddr = mram_rcnt[AW-1:0];

    always_comb
    begin
        count_next  = count_reg;
        mcount_next = mcount_reg;
        top_next    = top_reg;
        mtop_next   = mtop_reg;
        vram_we     = 1'b0;
        mram_we     = 1'b0;
        status_next = STATUS_OK;

        if (start)
        begin
            if (opcode == OP_PUSH)
            begin
                if (stack_full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    vram_we    = 1'b1;
                    top_next   = push_value;
                    count_next = count_reg + CNT_ONE;
                    if (new_min && (mcount_reg != CNT_MAX))
                    begin
                        mram_we     = 1'b1;
                        mtop_next   = push_value;
                        mcount_next = mcount_reg + CNT_ONE;
                    end
                end
            end
            else
            begin
                if (stack_empty)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CNT_ONE;
                    top_next   = sec_data;
                    if ((mcount_reg != '0) && (top_reg == mtop_reg))
                    begin
                        mcount_next = mcount_reg - CNT_ONE;
                        mtop_next   = msec_data;
                    end
                end
            end
        end
    end

    // Result fields from the post-operation state
    always_comb
    begin
        top_value_next = (count_next == '0) ? '0 : top_next;
        if ((count_next == '0) || (mcount_next == '0))
        begin
            min_value_next = VAL_MAX;
        end
        else
        begin
            min_value_next = mtop_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            mcount_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            mcount_reg <= mcount_next;
            done_reg   <= start;
        end
    end

    // Cached tops and result payload need no reset
    always_ff @(posedge clk)
    begin
        top_reg  <= top_next;
        mtop_reg <= mtop_next;
        if (start)
        begin
            top_value_reg  <= top_value_next;
            min_value_reg  <= min_value_next;
            depth_used_reg <= count_next;
            is_empty_reg   <= (count_next == '0);
            status_reg     <= status_next;
        end
    end

    mts_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_value_ram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (vram_waddr),
        .wdata (push_value),
        .raddr (vram_raddr),
        .rdata (sec_data)
    );

    mts_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_minima_ram (
        .clk   (clk),
        .we    (mram_we),
        .waddr (mram_waddr),
        .wdata (push_value),
        .raddr (mram_raddr),
        .rdata (msec_data)
    );

    assign busy       = 1'b0;
    assign done       = done_reg;
    assign top_value  = top_value_reg;
    assign min_value  = min_value_reg;
    assign depth_used = depth_used_reg;
    assign is_empty   = is_empty_reg;
    assign status     = status_reg;

    // Assertions
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("value count beyond stack depth");

    a_minima_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mcount_reg <= count_reg)
        else $error("minima count exceeds value count");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> done)
        else $error("accepted transaction gave no result");

    a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STATUS_FULL)) |-> (depth_used == CNT_MAX))
        else $error("full refusal reported with stack not full");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == STATUS_EMPTY)) |-> (is_empty && (depth_used == '0)))
        else $error("empty refusal reported with stack not empty");

endmodule

// ===== sim/min_tracking_stack_checker.sv =====
// Checker for the minimum-tracking stack: follows command and result transactions,
// keeps its own copy of the stack and compares every result field by field.
// Depends on mts_pkg.
module min_tracking_stack_checker
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic                               opcode,
    input  logic signed [VALUE_WIDTH-1:0]      push_value,
    input  logic                               done,
    input  logic signed [VALUE_WIDTH-1:0]      top_value,
    input  logic signed [VALUE_WIDTH-1:0]      min_value,
    input  logic [$clog2(STACK_DEPTH+1)-1:0]   depth_used,
    input  logic                               is_empty,
    input  logic [1:0]                         status,
    output int                                 fail_count,
    output int                                 pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam logic signed [VALUE_WIDTH-1:0] EMPTY_MIN = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] top;
        logic signed [VALUE_WIDTH-1:0] minv;
        logic [DW-1:0]                 depth;
        logic                          empty;
        status_t                       st;
    } stack_view_t;

    // Shadow stacks
    logic signed [VALUE_WIDTH-1:0] shadow_vals [STACK_DEPTH];
    logic signed [VALUE_WIDTH-1:0] shadow_mins [STACK_DEPTH];
    int                            n_vals;
    int                            n_mins;

    stack_view_t                   view_q [$];
    int                            mismatches;

    assign fail_count = mismatches;

    // Apply one command to the shadow stacks and return the view it should produce
    function automatic stack_view_t stack_apply(input logic op,
                                                input logic signed [VALUE_WIDTH-1:0] v);
        stack_view_t r;
        r.st = STATUS_OK;
        if (op == OP_PUSH)
        begin
            if (n_vals >= STACK_DEPTH)
                r.st = STATUS_FULL;
            else
            begin
                // inclusive compare keeps duplicate minima
                if ((n_mins == 0 || v <= shadow_mins[n_mins-1]) && n_mins < STACK_DEPTH)
                begin
                    shadow_mins[n_mins] = v;
                    n_mins++;
                end
                shadow_vals[n_vals] = v;
                n_vals++;
            end
        end
        else
        begin
            if (n_vals == 0)
                r.st = STATUS_EMPTY;
            else
            begin
                if (n_mins > 0 && shadow_vals[n_vals-1] == shadow_mins[n_mins-1])
                    n_mins--;
                n_vals--;
            end
        end
        if (n_vals == 0)
        begin
            r.top   = '0;
            r.minv  = EMPTY_MIN;
            r.empty = 1'b1;
        end
        else
        begin
            r.top   = shadow_vals[n_vals-1];
            r.minv  = (n_mins > 0) ? shadow_mins[n_mins-1] : EMPTY_MIN;
            r.empty = 1'b0;
        end
        r.depth = DW'(n_vals);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        stack_view_t want;
        if (!rst_n)
        begin
            n_vals     = 0;
            n_mins     = 0;
            mismatches = 0;
            view_q.delete();
            pending   <= 0;
        end
        else
        begin
            // result of the previous transaction is checked before this one is predicted
            if (done)
            begin
                if (view_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $write("%0t: unexpected result top=%0d min=%0d",
                               $realtime, top_value, min_value);
                        $display(" depth=%0d empty=%0b st=%0d",
                                 depth_used, is_empty, status);
                    end
                end
                else
                begin
                    want = view_q.pop_front();
                    if (top_value !== want.top || min_value !== want.minv
                        || depth_used !== want.depth || is_empty !== want.empty
                        || status !== want.st)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $write("%0t: mismatch exp top=%0d min=%0d",
                                   $realtime, want.top, want.minv);
                            $write(" depth=%0d empty=%0b st=%0d",
                                   want.depth, want.empty, want.st);
                            $write(", got top=%0d min=%0d", top_value, min_value);
                            $display(" depth=%0d empty=%0b st=%0d",
                                     depth_used, is_empty, status);
                        end
                    end
                end
            end
            if (start && !busy)
                view_q.push_back(stack_apply(opcode, push_value));
            pending <= view_q.size();
        end
    end

endmodule

// ===== sim/min_tracking_stack_core_tb.sv =====
// Testbench top for min_tracking_stack_core: drives command transactions and gives the verdict.
// Depends on mts_pkg, the core RTL and min_tracking_stack_checker.
module min_tracking_stack_core_tb
    import mts_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int DW          = $clog2(STACK_DEPTH + 1);
    localparam int WATCHDOG    = 2000;   // cycles without any transaction
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic                          opcode;
    logic signed [VALUE_WIDTH-1:0] push_value;
    logic                          done;
    logic signed [VALUE_WIDTH-1:0] top_value;
    logic signed [VALUE_WIDTH-1:0] min_value;
    logic [DW-1:0]                 depth_used;
    logic                          is_empty;
    logic [1:0]                    status;

    int fail_count;
    int pending;
    int idle_pct;       // chance, in percent, that the sender sits out a cycle
    int fill_level;     // rough occupancy, used only to steer the stimulus
    int quiet_cycles;

    min_tracking_stack_core #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .push_value (push_value),
        .done       (done),
        .top_value  (top_value),
        .min_value  (min_value),
        .depth_used (depth_used),
        .is_empty   (is_empty),
        .status     (status)
    );

    min_tracking_stack_checker #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .push_value (push_value),
        .done       (done),
        .top_value  (top_value),
        .min_value  (min_value),
        .depth_used (depth_used),
        .is_empty   (is_empty),
        .status     (status),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: any cycle with an accepted command or a result strobe counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Value mix: a narrow band gives plenty of equal values (duplicate minima),
    // extremes hit the sign boundaries, the rest is full 32-bit noise.
    function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
        int sel;
        sel = $urandom_range(9);
        case (sel) inside
            [0:3]:   return VALUE_WIDTH'($signed($urandom_range(16)) - 8);
            4:       return VAL_MAX;
            5:       return VAL_MIN;
            6:       return VAL_MIN + VALUE_WIDTH'($urandom_range(3));
            default: return $urandom;
        endcase
    endfunction

    // One command transaction. Idle cycles are inserted at the falling edge; the
    // transaction completes at the rising edge where busy is seen low.
    task automatic issue(input logic op, input logic signed [VALUE_WIDTH-1:0] v);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start      <= 1'b0;
            opcode     <= 1'($urandom_range(1));
            push_value <= $urandom;
            @(negedge clk);
        end
        start      <= 1'b1;
        opcode     <= op;
        push_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (op == OP_PUSH && fill_level < STACK_DEPTH)
            fill_level++;
        else if (op == OP_POP && fill_level > 0)
            fill_level--;
    endtask

    // Random transactions; pops carry random data which the block must ignore.
    task automatic random_run(input int n, input int push_pct);
        logic op;
        repeat (n)
        begin
            op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
            issue(op, (op == OP_PUSH) ? pick_value() : $urandom);
        end
    endtask

    initial
    begin
        clk_init_inputs:
        begin
            start        = 1'b0;
            opcode       = OP_PUSH;
            push_value   = '0;
            rst_n        = 1'b0;
            idle_pct     = 0;
            fill_level   = 0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: underflow, extremes, duplicate minima, pop of the last entry
        issue(OP_POP,  32'sd77);       // pop on empty stack
        issue(OP_PUSH, VAL_MAX);       // equal to the empty-stack minimum
        issue(OP_PUSH, VAL_MIN);
        issue(OP_PUSH, VAL_MIN);       // duplicate minimum must be kept
        issue(OP_PUSH, 32'sd5);        // above the minimum, stays off the minima stack
        issue(OP_PUSH, -32'sd1);
        issue(OP_POP,  VAL_MIN);
        issue(OP_POP,  '0);
        issue(OP_POP,  -32'sd1);       // first copy of the minimum goes
        issue(OP_POP,  VAL_MAX);       // second copy; minimum returns to VAL_MAX
        issue(OP_POP,  '0);            // last entry leaves
        issue(OP_POP,  -32'sd1);       // empty again
        issue(OP_PUSH, -32'sd7);
        issue(OP_PUSH, -32'sd7);
        issue(OP_PUSH, 32'sd3);
        issue(OP_PUSH, -32'sd8);
        issue(OP_PUSH, '0);
        issue(OP_POP,  32'sd1);
        issue(OP_POP,  32'sd1);
        issue(OP_POP,  32'sd1);
        issue(OP_POP,  32'sd1);
        issue(OP_POP,  32'sd1);
        issue(OP_POP,  32'sd1);        // one past empty

        // Back-to-back traffic around the empty end
        idle_pct = 0;
        random_run(200, 50);

        // Sparse sender: fill to the top, then dither there so pushes get refused
        idle_pct = 66;
        while (fill_level < STACK_DEPTH)
            random_run(1, 97);
        random_run(40, 70);

        // Light idling, even mix near full
        idle_pct = 7;
        random_run(100, 50);

        @(negedge clk);
        start <= 1'b0;

        // Drain outstanding results, then a short settle
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
